>>> rtl/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern search unit.
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

  // Largest pattern the unit can hold by default
  localparam int unsigned MaxPatternDef = 16;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CountW   = 32;
  localparam int unsigned PatBytes = 16;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LO  = 2'd0,
    CFG_PAT_HI  = 2'd1,
    CFG_PAT_LEN = 2'd2
  } cfg_reg_e;

  // Pattern setup seen by the compare logic
  typedef struct packed {
    logic [PatBytes-1:0][7:0] pattern;
    logic [LenW-1:0]          len;
  } cfg_t;

  // Per-region scan state
  typedef struct packed {
    logic [CountW-1:0] seen;
    logic              found;
  } region_t;

  // Compare outcome for the byte at hand
  typedef struct packed {
    logic              hit;
    logic [CountW-1:0] offset;
  } match_t;

endpackage

`default_nettype wire

>>> rtl/wildcard_byte_pattern_search_unit.sv
// Wildcard byte pattern search unit: top level with input and result registers.
//
// Usage:
//   Bytes of a region enter on the s_axis channel, one word per byte, with
//   s_axis_tlast on the final byte. The pattern (up to 16 bytes, zero byte is
//   a wildcard) and its length are written through the cfg_* port while the
//   unit is idle. For each region the m_axis channel carries at most one
//   word: tuser = 1 with the match start offset in tdata on the first match
//   lying wholly in the region, or tuser = 0 with tdata = 0 when the region
//   ends unmatched. Bytes after a match give nothing; the final byte still
//   resets the region state.
// Timing:
//   One byte per cycle sustained while result words are taken. An accepted
//   byte is held in the input register and compared there, and its result
//   word is loaded into the result register when the byte advances.
// Reset and stall:
//   Reset clears the region state and loads the pattern to all wildcards
//   with length 1. While a result waits on m_axis_tready the input register
//   still takes one more byte, then s_axis_tready drops until the result
//   is taken.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_search_unit
  import wbps_pkg::*;
#(
  parameter int unsigned MaxPattern = MaxPatternDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // Byte stream in
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,  // [7:0] data_byte
  input  wire logic                s_axis_tlast,  // last_byte
  // Result stream out
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [CountW-1:0]        m_axis_tdata,  // [31:0] match_offset
  output logic                     m_axis_tuser   // [0] match_found
);

  localparam int unsigned WinDepth = (MaxPattern > 1) ? MaxPattern - 1 : 1;

  cfg_t                     cfg;
  region_t                  region;
  match_t                   match;
  logic [WinDepth-1:0][7:0] win;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_free;
  logic       adv;
  logic       emit;

  logic              out_vld_q;
  logic              out_found_q;
  logic [CountW-1:0] out_offset_q;

  wbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  wbps_window #(.MaxPattern(MaxPattern)) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .hit_i    (match.hit),
    .win_o    (win),
    .region_o (region)
  );

  wbps_match #(.MaxPattern(MaxPattern)) u_match (
    .cfg_i    (cfg),
    .region_i (region),
    .win_i    (win),
    .byte_i   (in_byte_q),
    .match_o  (match)
  );

  // Advance the held byte when the result register can take a word
  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || adv;
  assign emit          = adv && !region.found && (match.hit || in_last_q);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_found_q  <= match.hit;
      out_offset_q <= match.hit ? match.offset : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_offset_q;
  assign m_axis_tuser  = out_found_q;

endmodule

`default_nettype wire

>>> rtl/wbps_cfg_regs.sv
// Configuration registers: pattern bytes and pattern length.
`timescale 1ns / 1ps
`default_nettype none

module wbps_cfg_regs
  import wbps_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  logic [CfgDataW-1:0] pat_lo_q, pat_hi_q;
  logic [LenW-1:0]     len_q;

  // Decode the write index; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= LenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAT_LO:  pat_lo_q <= cfg_wdata_i;
        CFG_PAT_HI:  pat_hi_q <= cfg_wdata_i;
        CFG_PAT_LEN: len_q    <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.pattern = {pat_hi_q, pat_lo_q};
  assign cfg_o.len     = len_q;

endmodule

`default_nettype wire

>>> rtl/wbps_window.sv
// Region state: recent byte window, byte count and found flag.
`timescale 1ns / 1ps
`default_nettype none

module wbps_window
  import wbps_pkg::*;
#(
  parameter int unsigned MaxPattern = MaxPatternDef,
  localparam int unsigned WinDepth  = (MaxPattern > 1) ? MaxPattern - 1 : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire logic [7:0]                byte_i,
  input  wire logic                      last_i,
  input  wire logic                      hit_i,
  output logic [WinDepth-1:0][7:0]       win_o,
  output region_t                        region_o
);

  logic [WinDepth-1:0][7:0] win_q, win_d;
  region_t                  region_q, region_d;

  // Shift the new byte in, or clear everything at the end of a region
  always_comb begin
    win_d    = win_q;
    region_d = region_q;
    if (adv_i) begin
      if (last_i) begin
        win_d    = '0;
        region_d = '0;
      end else begin
        for (int j = WinDepth - 1; j > 0; j--) begin
          win_d[j] = win_q[j-1];
        end
        win_d[0]       = byte_i;
        region_d.seen  = region_q.seen + CountW'(1);
        region_d.found = region_q.found | hit_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      region_q <= '0;
    end else begin
      win_q    <= win_d;
      region_q <= region_d;
    end
  end

  assign win_o    = win_q;
  assign region_o = region_q;

endmodule

`default_nettype wire

>>> rtl/wbps_match.sv
// Parallel wildcard compare of the pattern against window plus current byte.
`timescale 1ns / 1ps
`default_nettype none

module wbps_match
  import wbps_pkg::*;
#(
  parameter int unsigned MaxPattern = MaxPatternDef,
  localparam int unsigned WinDepth  = (MaxPattern > 1) ? MaxPattern - 1 : 1,
  localparam int unsigned IdxW      = (MaxPattern > 1) ? $clog2(MaxPattern) : 1
) (
  input  wire cfg_t                cfg_i,
  input  wire region_t             region_i,
  input  wire logic [WinDepth-1:0][7:0] win_i,
  input  wire logic [7:0]          byte_i,
  output match_t                   match_o
);

  logic [LenW-1:0] len_eff;
  logic [LenW-1:0] len_m1;
  logic [7:0]      seq [MaxPattern];
  logic            all_eq;
  logic            filled;

  // Clamp the length to what the window can hold
  assign len_eff = (cfg_i.len > LenW'(MaxPattern)) ? LenW'(MaxPattern) : cfg_i.len;
  assign len_m1  = len_eff - LenW'(1);

  // Newest byte first, then the window from most recent back
  always_comb begin
    seq[0] = byte_i;
    for (int j = 1; j < MaxPattern; j++) begin
      seq[j] = win_i[j-1];
    end
  end

  // Pattern byte k lines up with the byte len-1-k places back
  always_comb begin
    logic [LenW-1:0] diff;
    logic [7:0]      pb;
    logic [7:0]      sb;
    all_eq = 1'b1;
    for (int k = 0; k < MaxPattern; k++) begin
      diff = len_m1 - LenW'(k);
      pb   = cfg_i.pattern[k];
      sb   = seq[diff[IdxW-1:0]];
      if ((LenW'(k) < len_eff) && (pb != 8'd0) && (pb != sb)) begin
        all_eq = 1'b0;
      end
    end
  end

  // A match needs len bytes of the current region
  assign filled = region_i.seen >= CountW'(len_m1);

  always_comb begin
    if (len_eff == '0) begin
      match_o.hit    = 1'b1;
      match_o.offset = '0;
    end else begin
      match_o.hit    = filled & all_eq;
      match_o.offset = region_i.seen - CountW'(len_m1);
    end
  end

endmodule

`default_nettype wire

>>> rtl/wbps_checker.sv
// Port-level checks of the pattern search unit and their bind.
`timescale 1ns / 1ps
`default_nettype none

module wbps_checker
  import wbps_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [CountW-1:0] m_axis_tdata,
  input wire logic              m_axis_tuser
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // A not-found word carries a zero offset
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("not-found word with nonzero offset");

  // Input backpressure only comes from a stalled result
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // A fresh result word follows an accepted byte
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result word without an accepted byte");

endmodule

bind wildcard_byte_pattern_search_unit wbps_checker u_wbps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
